/* rtl/rgla_pkg.sv */
// types and constants shared by the row gcd/lcm accumulator
package rgla_pkg;

  localparam int unsigned VALUE_BITS = 31;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  last_item;
  } in_beat_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] row_lcm;
    logic [VALUE_BITS-1:0] row_gcd;
    logic                  lcm_overflow;
    logic                  bad_value;
  } out_beat_t;

  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_LOAD,
    KIND_FOLD
  } kind_e;

  typedef struct packed {
    kind_e                 kind;
    logic [VALUE_BITS-1:0] value;
    logic                  last_item;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV,
    ST_MUL,
    ST_CHK,
    ST_EMIT
  } state_e;

endpackage

/* rtl/rgla_front.sv */
// front end: accepts input beats and classifies them for the back end
module rgla_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rgla_pkg::in_beat_t in_data_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output rgla_pkg::entry_t  push_data_o
);
  import rgla_pkg::*;

  logic  row_start_q, row_start_d;
  logic  accept;
  kind_e kind;

  always_comb begin
    push_valid_o = in_valid_i;
    in_ready_o   = push_ready_i;
    accept       = in_valid_i && push_ready_i;
    if (in_data_i.value == '0) begin
      kind = KIND_ZERO;
    end else if (row_start_q) begin
      kind = KIND_LOAD;
    end else begin
      kind = KIND_FOLD;
    end
    push_data_o.kind      = kind;
    push_data_o.value     = in_data_i.value;
    push_data_o.last_item = in_data_i.last_item;
  end

  always_comb begin
    row_start_d = row_start_q;
    if (accept) begin
      if (in_data_i.last_item) begin
        row_start_d = 1'b1;
      end else if (in_data_i.value != '0) begin
        row_start_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_start_q <= 1'b1;
    end else begin
      row_start_q <= row_start_d;
    end
  end

endmodule

/* rtl/rgla_fifo.sv */
// short queue between front and back end
module rgla_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  rgla_pkg::entry_t push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output rgla_pkg::entry_t pop_data_o
);
  import rgla_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  entry_t          mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  always_comb begin
    push_ready_o = (count_q != CntW'(DEPTH));
    pop_valid_o  = (count_q != '0);
    pop_data_o   = mem_q[rd_ptr_q];
    push         = push_valid_i && push_ready_o;
    pop          = pop_valid_o && pop_ready_i;
    count_d      = count_q;
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/rgla_gcd.sv */
// iterative binary gcd engine, one subtract-and-shift step per cycle
module rgla_gcd (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [rgla_pkg::VALUE_BITS-1:0] a_i,
  input  logic [rgla_pkg::VALUE_BITS-1:0] b_i,
  output logic                            busy_o,
  output logic [rgla_pkg::VALUE_BITS-1:0] gcd_o
);
  import rgla_pkg::*;

  localparam int unsigned KW = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] a_q, a_d, b_q, b_d;
  logic [KW-1:0]         k_q, k_d;
  logic                  busy_q, busy_d;

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    k_d    = k_q;
    busy_d = busy_q;
    if (start_i) begin
      a_d    = a_i;
      b_d    = b_i;
      k_d    = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (a_q == b_q) begin
        busy_d = 1'b0;
      end else if (!a_q[0] && !b_q[0]) begin
        a_d = a_q >> 1;
        b_d = b_q >> 1;
        k_d = k_q + KW'(1);
      end else if (!a_q[0]) begin
        a_d = a_q >> 1;
      end else if (!b_q[0]) begin
        b_d = b_q >> 1;
      end else if (a_q > b_q) begin
        a_d = (a_q - b_q) >> 1;
      end else begin
        b_d = (b_q - a_q) >> 1;
      end
    end
  end

  assign busy_o = busy_q;
  assign gcd_o  = a_q << k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    k_q <= k_d;
  end

endmodule

/* rtl/rgla_core.sv */
// back end: folds queued values into running gcd and lcm, holds the result register
module rgla_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_ready_o,
  input  rgla_pkg::entry_t    q_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rgla_pkg::out_beat_t out_data_o
);
  import rgla_pkg::*;

  localparam int unsigned CntW = $clog2(VALUE_BITS + 1);

  state_e                  state_q, state_d;
  logic [VALUE_BITS-1:0]   gcd_q, lcm_q, cur_v_q, rem_q, quo_q, div_q;
  logic                    cur_last_q, started_q, ovf_q, zero_q;
  logic [CntW-1:0]         cnt_q;
  logic [2*VALUE_BITS-1:0] prod_q;
  out_beat_t               out_q;
  logic                    out_valid_q;
  logic                    pop, start, emit, gcds_done, prod_ovf;
  logic                    g_busy, l_busy;
  logic [VALUE_BITS-1:0]   g_res, l_res;
  logic [VALUE_BITS:0]     rem_sh, rem_diff;
  logic                    rem_ge;

  rgla_gcd u_gcd_row (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .a_i     (gcd_q),
    .b_i     (q_data_i.value),
    .busy_o  (g_busy),
    .gcd_o   (g_res)
  );

  rgla_gcd u_gcd_lcm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .a_i     (lcm_q),
    .b_i     (q_data_i.value),
    .busy_o  (l_busy),
    .gcd_o   (l_res)
  );

  assign gcds_done = !g_busy && !l_busy;
  assign rem_sh    = {rem_q, quo_q[VALUE_BITS-1]};
  assign rem_diff  = rem_sh - {1'b0, div_q};
  assign rem_ge    = (rem_sh >= {1'b0, div_q});
  assign prod_ovf  = (prod_q[2*VALUE_BITS-1:VALUE_BITS] != '0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          if (q_data_i.kind == KIND_FOLD) begin
            state_d = ST_GCD;
          end else if (q_data_i.last_item) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_GCD: begin
        if (gcds_done) begin
          if (!ovf_q) begin
            state_d = ST_DIV;
          end else if (cur_last_q) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_DIV: begin
        if (cnt_q == CntW'(1)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_CHK;
      end
      ST_CHK: begin
        state_d = cur_last_q ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (emit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    q_ready_o = (state_q == ST_IDLE);
    pop       = q_ready_o && q_valid_i;
    start     = pop && (q_data_i.kind == KIND_FOLD);
    emit      = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_last_q  <= 1'b0;
      started_q   <= 1'b0;
      ovf_q       <= 1'b0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (pop) begin
        cur_last_q <= q_data_i.last_item;
        if (q_data_i.kind == KIND_ZERO) begin
          zero_q <= 1'b1;
        end
        if (q_data_i.kind == KIND_LOAD) begin
          started_q <= 1'b1;
        end
      end
      if (state_q == ST_GCD && gcds_done) begin
        cnt_q <= CntW'(VALUE_BITS);
      end else if (state_q == ST_DIV) begin
        cnt_q <= cnt_q - CntW'(1);
      end
      if (state_q == ST_CHK && prod_ovf) begin
        ovf_q <= 1'b1;
      end
      if (emit) begin
        started_q <= 1'b0;
        ovf_q     <= 1'b0;
        zero_q    <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_v_q <= q_data_i.value;
      if (q_data_i.kind == KIND_LOAD) begin
        gcd_q <= q_data_i.value;
        lcm_q <= q_data_i.value;
      end
    end
    if (state_q == ST_GCD && gcds_done) begin
      gcd_q <= g_res;
      rem_q <= '0;
      quo_q <= lcm_q;
      div_q <= l_res;
    end
    // restoring divide, one quotient bit per cycle
    if (state_q == ST_DIV) begin
      rem_q <= rem_ge ? rem_diff[VALUE_BITS-1:0] : rem_sh[VALUE_BITS-1:0];
      quo_q <= {quo_q[VALUE_BITS-2:0], rem_ge};
    end
    if (state_q == ST_MUL) begin
      prod_q <= {{VALUE_BITS{1'b0}}, quo_q} * {{VALUE_BITS{1'b0}}, cur_v_q};
    end
    if (state_q == ST_CHK) begin
      lcm_q <= prod_ovf ? '1 : prod_q[VALUE_BITS-1:0];
    end
    if (emit) begin
      out_q.row_lcm      <= started_q ? lcm_q : '0;
      out_q.row_gcd      <= started_q ? gcd_q : '0;
      out_q.lcm_overflow <= ovf_q;
      out_q.bad_value    <= zero_q;
    end
  end

endmodule

/* rtl/row_gcd_lcm_accumulator_top.sv */
// each value passes through the back end one at a time, its pace set by the gcd engines
// and the divider: a zero value or a row's first value is taken in the idle state; any
// other value runs the binary gcd, the bit-serial divide, the multiply and the check;
// after the lcm saturates the divide is skipped; the row result passes from the emit
// state into the output register once that is free. reset clears all control state,
// the next value starts a new row; there is no clearing pass
module row_gcd_lcm_accumulator_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rgla_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rgla_pkg::out_beat_t out_data_o
);
  import rgla_pkg::*;

  logic   push_valid, push_ready, pop_valid, pop_ready;
  entry_t push_data, pop_data;

  rgla_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  rgla_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  rgla_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (pop_valid),
    .q_ready_o   (pop_ready),
    .q_data_i    (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // row_gcd is zero exactly when row_lcm is zero, as on a row without nonzero values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.row_gcd == '0) == (out_data_o.row_lcm == '0)))
    else $error("row_gcd and row_lcm disagree on an empty row");

  // saturated lcm reads as the maximum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.lcm_overflow) |-> (out_data_o.row_lcm == '1))
    else $error("lcm_overflow without saturated row_lcm");

  // an empty row must have held a zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.row_gcd == '0)) |-> out_data_o.bad_value)
    else $error("empty row without bad_value");

endmodule

/* tb/tb.sv */
// testbench for row_gcd_lcm_accumulator_top: directed rows, then random rows, checked beat by beat
module tb;
  import rgla_pkg::*;

  localparam logic [63:0] VAL_MAX = (64'd1 << VALUE_BITS) - 64'd1;
  localparam int RAND_BEATS = 1000;
  localparam int LONG_HOLD = 3000;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t want;
  } dir_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_beat_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_beat_t out_data_o;

  row_gcd_lcm_accumulator_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // row accumulator state
  logic [63:0] acc_gcd;
  logic [63:0] acc_lcm;
  bit          row_fresh = 1'b1;
  bit          lcm_sat;
  bit          zero_hit;

  out_beat_t row_results_q[$];
  dir_row_t  dir_tab[$];

  int  mismatches;
  int  beats_sent;
  int  rows_checked;
  int  zero_rows;
  int  sat_rows;
  int  cycles;
  bit  tx_quiet;
  bit  rx_quiet;
  int  hold_left;
  bit  long_hold_done;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  function automatic logic [63:0] euclid_gcd(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  // folds one value into the row, returns 1 with the row result when the row closes
  function automatic bit fold_value(input in_beat_t b, output out_beat_t res);
    logic [63:0] v;
    logic [63:0] g;
    logic [63:0] q;
    v = 64'(b.value) & VAL_MAX;
    res = '0;
    if (v == 0) begin
      zero_hit = 1'b1;
    end else if (row_fresh) begin
      acc_gcd = v;
      acc_lcm = v;
      row_fresh = 1'b0;
    end else begin
      acc_gcd = euclid_gcd(acc_gcd, v);
      if (!lcm_sat) begin
        g = euclid_gcd(acc_lcm, v);
        q = acc_lcm / g;
        if (q > VAL_MAX / v) begin
          acc_lcm = VAL_MAX;
          lcm_sat = 1'b1;
        end else begin
          acc_lcm = q * v;
        end
      end
    end
    if (!b.last_item) return 1'b0;
    res.row_lcm = row_fresh ? '0 : acc_lcm[VALUE_BITS-1:0];
    res.row_gcd = row_fresh ? '0 : acc_gcd[VALUE_BITS-1:0];
    res.lcm_overflow = lcm_sat;
    res.bad_value = zero_hit;
    acc_gcd = '0;
    acc_lcm = '0;
    row_fresh = 1'b1;
    lcm_sat = 1'b0;
    zero_hit = 1'b0;
    return 1'b1;
  endfunction

  function automatic void dir_add(input logic [63:0] v, input bit last, input bit typed,
                                  input out_beat_t want);
    dir_row_t row;
    row.beat.value = v[VALUE_BITS-1:0];
    row.beat.last_item = last;
    row.typed = typed;
    row.want = want;
    dir_tab.push_back(row);
  endfunction

  function automatic logic [63:0] rand_value(input logic [63:0] factor);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 64'd0;
    if (r < 7) return VAL_MAX - 64'($urandom_range(0, 3));
    if (r < 9) return 64'd1;
    if (r < 22) return 64'($urandom) & VAL_MAX;
    if (r < 32) return 64'd1 << $urandom_range(0, VALUE_BITS - 1);
    return (factor * 64'($urandom_range(1, 2000))) & VAL_MAX;
  endfunction

  function automatic logic [63:0] rand_factor();
    case ($urandom_range(0, 3))
      0: return 64'd1;
      1: return 64'($urandom_range(2, 64));
      2: return 64'($urandom_range(1000, 1 << 20));
      default: return 64'd1 << $urandom_range(1, 20);
    endcase
  endfunction

  task automatic send_beat(input in_beat_t b, input bit typed, input out_beat_t want);
    int gap;
    out_beat_t res;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    beats_sent++;
    if (fold_value(b, res)) row_results_q.push_back(typed ? want : res);
  endtask

  task automatic take_result(input out_beat_t got);
    out_beat_t want;
    if (row_results_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected row beat: lcm=%h gcd=%h ovf=%b bad=%b",
                 got.row_lcm, got.row_gcd, got.lcm_overflow, got.bad_value);
      return;
    end
    want = row_results_q.pop_front();
    rows_checked++;
    if (got.bad_value) zero_rows++;
    if (got.lcm_overflow) sat_rows++;
    if (got.row_lcm !== want.row_lcm || got.row_gcd !== want.row_gcd ||
        got.lcm_overflow !== want.lcm_overflow || got.bad_value !== want.bad_value) begin
      mismatches++;
      if (mismatches <= 10)
        $display("row %0d: exp lcm=%h gcd=%h ovf=%b bad=%b, got lcm=%h gcd=%h ovf=%b bad=%b",
                 rows_checked, want.row_lcm, want.row_gcd, want.lcm_overflow, want.bad_value,
                 got.row_lcm, got.row_gcd, got.lcm_overflow, got.bad_value);
    end
  endtask

  // result side: checks and random back-pressure, one long hold-off
  always @(posedge clk_i) begin
    int gap;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) take_result(out_data_o);
      if ($urandom_range(0, 499) == 0) rx_quiet = !rx_quiet;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!long_hold_done && rows_checked >= 30) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
        out_ready_i <= 1'b0;
      end else begin
        gap = rx_quiet ? 0 : pick_gap();
        if (gap > 0) begin
          hold_left = gap - 1;
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d rows outstanding", cycles, row_results_q.size());
      $display("row_gcd_lcm_accumulator_top: mismatch");
      $finish;
    end
  end

  initial begin
    int rand_sent;
    int row_len;
    logic [63:0] factor;
    in_beat_t b;

    // single values, extremes, empty rows, saturation, zeros mixed in
    dir_add(64'd1, 1'b1, 1'b1, '{31'd1, 31'd1, 1'b0, 1'b0});
    dir_add(VAL_MAX, 1'b1, 1'b1, '{VAL_MAX[30:0], VAL_MAX[30:0], 1'b0, 1'b0});
    dir_add(64'd0, 1'b1, 1'b1, '{31'd0, 31'd0, 1'b0, 1'b1});
    dir_add(64'd0, 1'b0, 1'b0, '0);
    dir_add(64'd0, 1'b1, 1'b1, '{31'd0, 31'd0, 1'b0, 1'b1});
    dir_add(64'd12, 1'b0, 1'b0, '0);
    dir_add(64'd18, 1'b0, 1'b0, '0);
    dir_add(64'd30, 1'b1, 1'b0, '0);
    dir_add(VAL_MAX, 1'b0, 1'b0, '0);
    dir_add(VAL_MAX - 64'd1, 1'b1, 1'b1, '{VAL_MAX[30:0], 31'd1, 1'b1, 1'b0});
    dir_add(64'd0, 1'b0, 1'b0, '0);
    dir_add(64'd7, 1'b0, 1'b0, '0);
    dir_add(64'd0, 1'b0, 1'b0, '0);
    dir_add(64'd14, 1'b1, 1'b0, '0);
    dir_add(64'd1 << 30, 1'b0, 1'b0, '0);
    dir_add(64'd3 << 28, 1'b0, 1'b0, '0);
    dir_add(64'd1 << 20, 1'b1, 1'b0, '0);
    dir_add(64'd5, 1'b0, 1'b0, '0);
    dir_add(64'd5, 1'b1, 1'b0, '0);
    dir_add(64'd1 << 30, 1'b0, 1'b0, '0);
    dir_add(64'd1, 1'b1, 1'b0, '0);
    dir_add(64'd9, 1'b0, 1'b0, '0);
    dir_add(64'd0, 1'b1, 1'b0, '0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_beat(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].want);

    rand_sent = 0;
    while (rand_sent < RAND_BEATS) begin
      row_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      factor = rand_factor();
      for (int k = 0; k < row_len; k++) begin
        if ($urandom_range(0, 79) == 0) tx_quiet = !tx_quiet;
        b.value = rand_value(factor);
        b.last_item = (k == row_len - 1);
        send_beat(b, 1'b0, '0);
        rand_sent++;
      end
    end
    in_valid_i <= 1'b0;

    while (row_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d beats, checked %0d rows (%0d with zero values, %0d saturated)",
             beats_sent, rows_checked, zero_rows, sat_rows);
    $display("long result hold-off %0s, %0d mismatches", long_hold_done ? "done" : "skipped",
             mismatches);
    if (mismatches == 0) begin
      $display("row_gcd_lcm_accumulator_top: match");
    end else begin
      $display("row_gcd_lcm_accumulator_top: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/rgla_pkg.sv
rtl/rgla_front.sv
rtl/rgla_fifo.sv
rtl/rgla_gcd.sv
rtl/rgla_core.sv
rtl/row_gcd_lcm_accumulator_top.sv
tb/tb.sv
